### rtl/gssb_pkg.sv
// Shared types, constants and the channel map of the gated strip scaler event builder.
package gssb_pkg;

  // Default sizes of the strip array and the trigger scalers.
  localparam int STRIPS_PER_SLOT_DEF   = 96;
  localparam int SLOT_COUNT_DEF        = 4;
  localparam int TRIG_LINES_DEF        = 5;
  localparam int STRIP_COUNT_WIDTH_DEF = 19;

  // Fixed widths of the frame fields.
  localparam int MAX_SLOTS     = 4;
  localparam int MAX_CHANNELS  = 120;
  localparam int MAX_TRIG      = 5;
  localparam int SCALAR_WIDTH  = 31;
  localparam int WORD_WIDTH    = 32;
  localparam int CHAN_WIDTH    = 7;
  localparam int STRIP_FIELD_W = 24;

  // Event word codes.
  localparam logic [31:0] HDR_BASE      = 32'hE480_0000;
  localparam logic [31:0] TRAILER_WORD  = 32'hFFFF_FFFF;
  localparam int          SLOT_HDR_BASE = 13;
  localparam logic [30:0] TIME_STEP     = 31'd8;

  // One input frame.
  typedef struct packed {
    logic        gate_level;
    logic        busy_level;
    logic        trig_present;
    logic [4:0]  trig_hits;
    logic [63:0] slot0_hits_lo;
    logic [55:0] slot0_hits_hi;
    logic [63:0] slot1_hits_lo;
    logic [55:0] slot1_hits_hi;
    logic [63:0] slot2_hits_lo;
    logic [55:0] slot2_hits_hi;
    logic [63:0] slot3_hits_lo;
    logic [55:0] slot3_hits_hi;
  } in_t;

  // One event word.
  typedef struct packed {
    logic [31:0] event_word;
    logic        event_last;
  } out_t;

  // Control handed to every strip cell.
  typedef struct packed {
    logic step;
    logic gate;
    logic load;
    logic shift;
  } strip_ctl_t;

  // Control produced by the word sequencer.
  typedef struct packed {
    logic emit;
    logic last;
    logic shift_scalar;
    logic shift_strip;
    logic building;
  } seq_ctl_t;

  // Sequencer phases of one event.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_SCALAR,
    ST_SLOT_HDR,
    ST_STRIP,
    ST_TRAILER
  } seq_state_t;

  // Channel read by strip j of a slot. The first 96 strips are the active channels,
  // the rest follow with the remaining channels in ascending order.
  function automatic logic [6:0] chan_map(input logic [6:0] j);
    logic [6:0] c;
    if (j < 7'd24) begin
      c = j;
    end else if (j < 7'd48) begin
      c = j + 7'd7;
    end else if (j < 7'd72) begin
      c = j + 7'd16;
    end else if (j < 7'd96) begin
      c = j + 7'd24;
    end else if (j < 7'd103) begin
      c = j - 7'd72;
    end else if (j < 7'd112) begin
      c = j - 7'd48;
    end else begin
      c = j - 7'd24;
    end
    return c;
  endfunction

endpackage

### rtl/gssb_strip_cell.sv
// One strip cell: a wrapping hit counter and a snapshot stage of the readout chain.
module gssb_strip_cell
  import gssb_pkg::*;
#(
  parameter int STRIP_COUNT_WIDTH = STRIP_COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  strip_ctl_t                   ctl,
  input  logic                         hit,
  input  logic [STRIP_COUNT_WIDTH-1:0] snap_in,
  output logic [STRIP_COUNT_WIDTH-1:0] snap_out
);

  logic [STRIP_COUNT_WIDTH-1:0] count_r;
  logic [STRIP_COUNT_WIDTH-1:0] snap_r;

  // A high gate clears the counter; otherwise a hit adds one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.step) begin
      if (ctl.gate) begin
        count_r <= '0;
      end else if (hit) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // The snapshot takes the count from before this frame's clear, then shifts toward the head.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      snap_r <= count_r;
    end else if (ctl.shift) begin
      snap_r <= snap_in;
    end
  end

  assign snap_out = snap_r;

endmodule

### rtl/gssb_word_seq.sv
// Event word sequencer: walks header, scalers, slot headers, strips and trailer.
module gssb_word_seq
  import gssb_pkg::*;
#(
  parameter int STRIPS_PER_SLOT   = STRIPS_PER_SLOT_DEF,
  parameter int SLOT_COUNT        = SLOT_COUNT_DEF,
  parameter int TRIG_LINES        = TRIG_LINES_DEF,
  parameter int STRIP_COUNT_WIDTH = STRIP_COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         start,
  input  logic [SCALAR_WIDTH-1:0]      scalar_head,
  input  logic [STRIP_COUNT_WIDTH-1:0] strip_head,
  output seq_ctl_t                     ctl,
  output logic [WORD_WIDTH-1:0]        word
);

  localparam int NSCAL = 3 + TRIG_LINES;
  localparam int SCW   = $clog2(NSCAL);
  localparam int SLW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SW    = (STRIPS_PER_SLOT > 1) ? $clog2(STRIPS_PER_SLOT) : 1;

  seq_state_t     state_r, state_nxt;
  logic [SCW-1:0] scalar_idx_r, scalar_idx_nxt;
  logic [SLW-1:0] slot_idx_r, slot_idx_nxt;
  logic [SW-1:0]  strip_idx_r, strip_idx_nxt;

  // Next phase and position, advanced once per accepted frame.
  always_comb begin
    state_nxt      = state_r;
    scalar_idx_nxt = scalar_idx_r;
    slot_idx_nxt   = slot_idx_r;
    strip_idx_nxt  = strip_idx_r;
    if (step) begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_nxt = ST_HDR;
          end
        end
        ST_HDR: begin
          state_nxt      = ST_SCALAR;
          scalar_idx_nxt = '0;
        end
        ST_SCALAR: begin
          if (scalar_idx_r == SCW'(NSCAL - 1)) begin
            state_nxt    = ST_SLOT_HDR;
            slot_idx_nxt = '0;
          end else begin
            scalar_idx_nxt = scalar_idx_r + 1'b1;
          end
        end
        ST_SLOT_HDR: begin
          state_nxt     = ST_STRIP;
          strip_idx_nxt = '0;
        end
        ST_STRIP: begin
          if (strip_idx_r == SW'(STRIPS_PER_SLOT - 1)) begin
            if (slot_idx_r == SLW'(SLOT_COUNT - 1)) begin
              state_nxt = ST_TRAILER;
            end else begin
              state_nxt    = ST_SLOT_HDR;
              slot_idx_nxt = slot_idx_r + 1'b1;
            end
          end else begin
            strip_idx_nxt = strip_idx_r + 1'b1;
          end
        end
        ST_TRAILER: begin
          state_nxt = ST_IDLE;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scalar_idx_r <= '0;
      slot_idx_r   <= '0;
      strip_idx_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      scalar_idx_r <= scalar_idx_nxt;
      slot_idx_r   <= slot_idx_nxt;
      strip_idx_r  <= strip_idx_nxt;
    end
  end

  // Word contents and chain shifts for the current phase.
  always_comb begin
    ctl.building     = (state_r != ST_IDLE);
    ctl.emit         = step && (state_r != ST_IDLE);
    ctl.last         = 1'b0;
    ctl.shift_scalar = 1'b0;
    ctl.shift_strip  = 1'b0;
    word             = HDR_BASE;
    case (state_r)
      ST_IDLE: begin
        word = HDR_BASE;
      end
      ST_HDR: begin
        word = HDR_BASE;
      end
      ST_SCALAR: begin
        word             = {1'b0, scalar_head};
        ctl.shift_scalar = step;
      end
      ST_SLOT_HDR: begin
        word = HDR_BASE | (32'(SLOT_HDR_BASE) + 32'(slot_idx_r));
      end
      ST_STRIP: begin
        word            = {1'b0, chan_map(7'(strip_idx_r)), STRIP_FIELD_W'(strip_head)};
        ctl.shift_strip = step;
      end
      ST_TRAILER: begin
        word     = TRAILER_WORD;
        ctl.last = 1'b1;
      end
      default: begin
        word = HDR_BASE;
      end
    endcase
  end

endmodule

### rtl/gated_strip_scaler_event_builder_top.sv
// Top level of the gated strip scaler event builder: scalers, strip cell chain and output stage.
// Throughput: one frame request is taken every cycle while the output stage can accept.
// The word caused by a frame is shown in the cycle after that frame is taken.
// An event follows a gate rise seen while idle and emits 5 + TRIG_LINES +
// SLOT_COUNT * (STRIPS_PER_SLOT + 1) words, one per frame after the rise (398 by default).
// Reset (synchronous, rst_n low) clears all counters, the sequencer and the output stage.
module gated_strip_scaler_event_builder_top
  import gssb_pkg::*;
#(
  parameter int STRIPS_PER_SLOT   = STRIPS_PER_SLOT_DEF,
  parameter int SLOT_COUNT        = SLOT_COUNT_DEF,
  parameter int TRIG_LINES        = TRIG_LINES_DEF,
  parameter int STRIP_COUNT_WIDTH = STRIP_COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int NSCAL  = 3 + TRIG_LINES;
  localparam int NCELLS = SLOT_COUNT * STRIPS_PER_SLOT;

  logic                         in_acc;
  logic                         rise;
  logic                         start;
  logic                         gate_prev_r;
  logic [TRIG_LINES-1:0]        trig_prev_r;
  logic [TRIG_LINES-1:0]        edges;
  logic [SCALAR_WIDTH-1:0]      window_r, window_nxt;
  logic [SCALAR_WIDTH-1:0]      live_r;
  logic [SCALAR_WIDTH-1:0]      busy_r;
  logic [SCALAR_WIDTH-1:0]      trig_r [TRIG_LINES];
  logic [SCALAR_WIDTH-1:0]      scal_r [NSCAL];
  logic [MAX_SLOTS-1:0][MAX_CHANNELS-1:0] slot_hits;
  logic [STRIP_COUNT_WIDTH-1:0] snap_chain [NCELLS+1];
  strip_ctl_t                   cell_ctl;
  seq_ctl_t                     seq_ctl;
  logic [WORD_WIDTH-1:0]        seq_word;
  logic                         out_valid_r;
  out_t                         out_r;

  // Handshake: a new frame is taken whenever the output stage is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Gate and trigger edge detection.
  assign rise       = in_data.gate_level && !gate_prev_r;
  assign start      = rise && !seq_ctl.building;
  assign edges      = in_data.trig_present ?
                      (in_data.trig_hits[TRIG_LINES-1:0] & ~trig_prev_r) : '0;
  assign window_nxt = rise ? (window_r + 1'b1) : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_prev_r <= 1'b1;
      trig_prev_r <= '0;
      window_r    <= '0;
    end else if (in_acc) begin
      gate_prev_r <= in_data.gate_level;
      window_r    <= window_nxt;
      if (in_data.trig_present) begin
        trig_prev_r <= in_data.trig_hits[TRIG_LINES-1:0];
      end
    end
  end

  // Busy and live time, cleared while the gate is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      busy_r <= '0;
    end else if (in_acc) begin
      if (in_data.gate_level) begin
        live_r <= '0;
        busy_r <= '0;
      end else if (in_data.busy_level) begin
        busy_r <= busy_r + TIME_STEP;
      end else begin
        live_r <= live_r + TIME_STEP;
      end
    end
  end

  // Trigger line edge counters.
  for (genvar t = 0; t < TRIG_LINES; t++) begin : g_trig
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        trig_r[t] <= '0;
      end else if (in_acc) begin
        if (in_data.gate_level) begin
          trig_r[t] <= '0;
        end else if (edges[t]) begin
          trig_r[t] <= trig_r[t] + 1'b1;
        end
      end
    end
  end

  // Scaler snapshot chain: window, live, busy, then the trigger lines, read from the head.
  for (genvar k = 0; k < NSCAL; k++) begin : g_scal
    logic [SCALAR_WIDTH-1:0] load_val;
    if (k == 0) begin : g_win
      assign load_val = window_nxt;
    end else if (k == 1) begin : g_live
      assign load_val = live_r;
    end else if (k == 2) begin : g_busy
      assign load_val = busy_r;
    end else begin : g_trg
      assign load_val = trig_r[k-3];
    end
    always_ff @(posedge clk) begin
      if (in_acc && start) begin
        scal_r[k] <= load_val;
      end else if (seq_ctl.shift_scalar) begin
        if (k == NSCAL - 1) begin
          scal_r[k] <= '0;
        end else begin
          scal_r[k] <= scal_r[(k+1) % NSCAL];
        end
      end
    end
  end

  // Slot hit vectors as one wide word per slot.
  always_comb begin
    slot_hits[0] = {in_data.slot0_hits_hi, in_data.slot0_hits_lo};
    slot_hits[1] = {in_data.slot1_hits_hi, in_data.slot1_hits_lo};
    slot_hits[2] = {in_data.slot2_hits_hi, in_data.slot2_hits_lo};
    slot_hits[3] = {in_data.slot3_hits_hi, in_data.slot3_hits_lo};
  end

  // Control shared by all strip cells.
  always_comb begin
    cell_ctl.step  = in_acc;
    cell_ctl.gate  = in_data.gate_level;
    cell_ctl.load  = in_acc && start;
    cell_ctl.shift = seq_ctl.shift_strip;
  end

  // Strip cell chain, slot-major; the snapshot moves one cell toward the head per strip word.
  assign snap_chain[NCELLS] = '0;
  for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
    for (genvar j = 0; j < STRIPS_PER_SLOT; j++) begin : g_strip
      gssb_strip_cell #(
        .STRIP_COUNT_WIDTH(STRIP_COUNT_WIDTH)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cell_ctl),
        .hit     (slot_hits[s][chan_map(7'(j))]),
        .snap_in (snap_chain[s*STRIPS_PER_SLOT+j+1]),
        .snap_out(snap_chain[s*STRIPS_PER_SLOT+j])
      );
    end
  end

  // Event word sequencer.
  gssb_word_seq #(
    .STRIPS_PER_SLOT  (STRIPS_PER_SLOT),
    .SLOT_COUNT       (SLOT_COUNT),
    .TRIG_LINES       (TRIG_LINES),
    .STRIP_COUNT_WIDTH(STRIP_COUNT_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_acc),
    .start      (start),
    .scalar_head(scal_r[0]),
    .strip_head (snap_chain[0]),
    .ctl        (seq_ctl),
    .word       (seq_word)
  );

  // Output register holding one word request until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_ctl.emit) begin
      out_r.event_word <= seq_word;
      out_r.event_last <= seq_ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
